// File: src/afg_pkg.sv
package afg_pkg;

  // Field widths fixed by the item formats.
  localparam int IDX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int SLOT_W     = 4;
  localparam int COEF_IN_W  = 16;
  localparam int OUT_W      = 24;
  localparam int COEF_SLOTS = 12;

  // Base coordinates are Q2.15 and span -32768..32768.
  localparam int BASE_W    = 17;
  localparam int BASE_ONE  = 32768;
  localparam int DIV_STEPS = 17;
  localparam int MAG_W     = 13;

  // Rounding from 27 to 16 fraction bits.
  localparam int RND_SHIFT = 11;
  localparam int RND_HALF  = 1024;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_ALIGN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH   = 3'd4;

  // Kinds of work passed from the front to the back.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  typedef struct packed {
    logic                        op;
    logic [SLOT_W-1:0]           coef_index;
    logic signed [COEF_IN_W-1:0] coef_value;
    logic [IDX_W-1:0]            col_index;
    logic [IDX_W-1:0]            row_index;
    logic [IDX_W-1:0]            depth_index;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] grid_x;
    logic signed [OUT_W-1:0] grid_y;
    logic signed [OUT_W-1:0] grid_z;
    logic                    index_error;
  } result_t;

  typedef struct packed {
    logic              grid_mode;
    logic              corner_align;
    logic [SIZE_W-1:0] grid_width;
    logic [SIZE_W-1:0] grid_height;
    logic [SIZE_W-1:0] grid_depth;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [SLOT_W-1:0]           slot;
    logic signed [COEF_IN_W-1:0] coef;
    logic [IDX_W-1:0]            col;
    logic [IDX_W-1:0]            row;
    logic [IDX_W-1:0]            dep;
  } work_t;

endpackage

// File: src/afg_front.sv
module afg_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  afg_pkg::cfg_t cfg,
  input  logic          push,
  output logic          full,
  input  afg_pkg::item_t item,
  output logic          q_empty,
  output afg_pkg::work_t q_head,
  input  logic          q_pop
);

  localparam logic [31:0] MaxDim = 32'(MAX_DIM);

  afg_pkg::work_t    entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  afg_pkg::work_t    work;
  logic              bad;
  logic              keep;
  logic              wr_en;
  logic              rd_en;

  function automatic logic axis_bad(input logic [afg_pkg::IDX_W-1:0] idx,
                                    input logic [afg_pkg::SIZE_W-1:0] size);
    axis_bad = (size == '0) || (32'(size) > MaxDim) ||
               ({1'b0, idx} >= size);
  endfunction

  // Classify the incoming item; loads to slots past the store are dropped.
  always_comb begin
    bad = axis_bad(item.col_index, cfg.grid_width) ||
          axis_bad(item.row_index, cfg.grid_height) ||
          (cfg.grid_mode && axis_bad(item.depth_index, cfg.grid_depth));
    work.slot = item.coef_index;
    work.coef = item.coef_value;
    work.col  = item.col_index;
    work.row  = item.row_index;
    work.dep  = item.depth_index;
    if (item.op == afg_pkg::OP_LOAD) begin
      work.kind = afg_pkg::KIND_LOAD;
      keep      = (32'(item.coef_index) < 32'(afg_pkg::COEF_SLOTS));
    end else begin
      work.kind = bad ? afg_pkg::KIND_BAD : afg_pkg::KIND_POINT;
      keep      = 1'b1;
    end
  end

  assign full    = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign q_head  = entry[rd_ptr];
  assign wr_en   = push && !full && keep;
  assign rd_en   = q_pop && !q_empty;

  // Two-entry queue between the front and the back.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// File: src/afg_div.sv
module afg_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [afg_pkg::MAG_W-1:0]           mag,
  input  logic [afg_pkg::SIZE_W-1:0]          dvs,
  input  logic                                zero,
  input  logic                                neg,
  output logic                                busy,
  output logic signed [afg_pkg::BASE_W-1:0]   base
);

  localparam int NumW = afg_pkg::MAG_W + 17;
  localparam int LowW = afg_pkg::DIV_STEPS;
  localparam int RemW = afg_pkg::SIZE_W + 1;

  logic [NumW-1:0]              numer;
  logic [LowW-1:0]              low;
  logic [RemW-1:0]              rem;
  logic [RemW-1:0]              dvs2;
  logic [afg_pkg::BASE_W-1:0]   quo;
  logic [4:0]                   cnt;
  logic                         zero_r;
  logic                         neg_r;
  logic [RemW:0]                trial;
  logic                         qbit;

  // Numerator of the rounded quotient: mag * 2^16 + d over 2d.
  assign numer = {1'b0, mag, 16'b0} + NumW'(dvs);
  assign trial = {rem, low[LowW-1]};
  assign qbit  = (trial >= {1'b0, dvs2});

  // One quotient bit each cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= RemW'(numer[NumW-1:LowW]);
      low    <= numer[LowW-1:0];
      dvs2   <= {dvs, 1'b0};
      zero_r <= zero;
      neg_r  <= neg;
    end else if (busy) begin
      rem <= qbit ? RemW'(trial - {1'b0, dvs2}) : trial[RemW-1:0];
      low <= {low[LowW-2:0], 1'b0};
      quo <= {quo[afg_pkg::BASE_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(afg_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (zero_r) begin
      base = '0;
    end else if (neg_r) begin
      base = -$signed(quo);
    end else begin
      base = $signed(quo);
    end
  end

endmodule

// File: src/afg_back.sv
module afg_back #(
  parameter int COEF_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  afg_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  afg_pkg::work_t  q_head,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output afg_pkg::result_t result
);

  localparam int ProdW = COEF_WIDTH + afg_pkg::BASE_W;
  localparam int AccW  = COEF_WIDTH + afg_pkg::BASE_W + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MAC  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                               state;
  logic [1:0]                               state_next;
  logic signed [COEF_WIDTH-1:0]             coef [afg_pkg::COEF_SLOTS];
  logic signed [COEF_WIDTH-1:0]             ops [3][4];
  logic signed [afg_pkg::BASE_W-1:0]        bops [4];
  logic signed [ProdW-1:0]                  prod [3];
  logic signed [AccW-1:0]                   acc [3];
  logic                                     pvalid;
  logic [2:0]                               step;
  logic [2:0]                               terms;
  logic                                     three;
  logic                                     err;
  logic                                     res_valid;
  logic                                     out_free;
  logic                                     start;
  logic                                     div_busy [3];
  logic signed [afg_pkg::BASE_W-1:0]        base [3];
  logic [afg_pkg::IDX_W-1:0]                idx [3];
  logic [afg_pkg::SIZE_W-1:0]               size [3];
  logic signed [31:0]                       coef_ext;

  function automatic logic signed [afg_pkg::OUT_W-1:0] finish(
      input logic signed [AccW-1:0] a);
    logic signed [AccW:0] t;
    logic signed [AccW:0] r;
    t = {a[AccW-1], a} + (AccW+1)'(afg_pkg::RND_HALF);
    r = t >>> afg_pkg::RND_SHIFT;
    if (r > (AccW+1)'(8388607)) begin
      finish = 24'sh7FFFFF;
    end else if (r < -(AccW+1)'(8388608)) begin
      finish = -24'sh800000;
    end else begin
      finish = r[afg_pkg::OUT_W-1:0];
    end
  endfunction

  assign idx[0]  = q_head.col;
  assign idx[1]  = q_head.row;
  assign idx[2]  = q_head.dep;
  assign size[0] = cfg.grid_width;
  assign size[1] = cfg.grid_height;
  assign size[2] = cfg.grid_depth;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign start    = q_pop && (q_head.kind == afg_pkg::KIND_POINT);
  assign out_free = !res_valid || pop;
  assign empty    = !res_valid;
  assign terms    = three ? 3'd4 : 3'd3;
  assign coef_ext = 32'(q_head.coef);

  // One divider per axis forms the normalized base coordinate.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [14:0]            n;
    logic                          neg;
    logic [afg_pkg::MAG_W-1:0]     mag;
    logic [afg_pkg::SIZE_W-1:0]    d;
    logic                          zero;
    always_comb begin
      n    = $signed({2'b0, idx[a], 1'b0}) - $signed({2'b0, size[a]} - 15'd1);
      neg  = n[14];
      mag  = neg ? 13'(-n) : n[12:0];
      d    = cfg.corner_align ? size[a] - 13'd1 : size[a];
      zero = (size[a] == 13'd1) || (d == '0);
    end
    afg_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (start),
      .mag   (mag),
      .dvs   (d),
      .zero  (zero),
      .neg   (neg),
      .busy  (div_busy[a]),
      .base  (base[a])
    );
  end

  // Control sequence for one unit of work.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          if (q_head.kind == afg_pkg::KIND_POINT) begin
            state_next = S_DIV;
          end else if (q_head.kind == afg_pkg::KIND_BAD) begin
            state_next = S_FIN;
          end
        end
      end
      S_DIV: begin
        if (!div_busy[0] && !div_busy[1] && !div_busy[2]) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (step == terms) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Coefficient store, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < afg_pkg::COEF_SLOTS; k++) begin
        coef[k] <= '0;
      end
    end else if (q_pop && q_head.kind == afg_pkg::KIND_LOAD) begin
      coef[q_head.slot] <= coef_ext[COEF_WIDTH-1:0];
    end
  end

  // Latch mode and error flag of the current point.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      three <= cfg.grid_mode;
      err   <= (q_head.kind == afg_pkg::KIND_BAD);
    end
  end

  // Operand lines feed one multiplier per row, one term a cycle.
  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 4; k++) begin
          if (three) begin
            ops[r][k] <= coef[r * 4 + k];
          end else if (k < 3 && r < 2) begin
            ops[r][k] <= coef[r * 3 + k];
          end else begin
            ops[r][k] <= '0;
          end
        end
        acc[r] <= '0;
      end
      bops[0] <= base[0];
      bops[1] <= base[1];
      bops[2] <= three ? base[2] : 17'(afg_pkg::BASE_ONE);
      bops[3] <= 17'(afg_pkg::BASE_ONE);
      step    <= '0;
      pvalid  <= 1'b0;
    end else if (state == S_MAC) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          ops[r][k] <= ops[r][k + 1];
        end
        prod[r] <= ops[r][0] * bops[0];
        if (pvalid) begin
          acc[r] <= acc[r] + AccW'(prod[r]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        bops[k] <= bops[k + 1];
      end
      pvalid <= (step < terms);
      step   <= step + 3'd1;
    end
  end

  // Result register parts the back from the consumer.
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      if (err) begin
        result.grid_x <= '0;
        result.grid_y <= '0;
        result.grid_z <= '0;
      end else begin
        result.grid_x <= finish(acc[0]);
        result.grid_y <= finish(acc[1]);
        result.grid_z <= three ? finish(acc[2]) : '0;
      end
      result.index_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// File: src/affine_grid_generator.sv
// Channel   Handshake           Payload
// item      push / full         afg_pkg::item_t (load or point)
// result    pop / empty         afg_pkg::result_t
// config    cfg_we (no wait)    cfg_index, cfg_data
//
// A load is taken in the back's idle state and an out-of-range point passes
// straight to the result step; a valid point is dequeued, waits for the serial
// base-coordinate dividers, then takes one matrix column per step and drains products.
// A result that is not taken holds the back in its last step, while the
// two-entry queue keeps accepting items until it is full.
// Reset is synchronous and clears the coefficient store and all queues.
module affine_grid_generator #(
  parameter int MAX_DIM    = 4096,
  parameter int COEF_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  afg_pkg::item_t                     item,
  output logic                               empty,
  input  logic                               pop,
  output afg_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [afg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afg_pkg::SIZE_W-1:0]         cfg_data
);

  afg_pkg::cfg_t  cfg;
  afg_pkg::work_t q_head;
  logic           q_empty;
  logic           q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_mode    <= 1'b0;
      cfg.corner_align <= 1'b0;
      cfg.grid_width   <= 13'd1;
      cfg.grid_height  <= 13'd1;
      cfg.grid_depth   <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        afg_pkg::CFG_GRID_MODE:    cfg.grid_mode    <= cfg_data[0];
        afg_pkg::CFG_CORNER_ALIGN: cfg.corner_align <= cfg_data[0];
        afg_pkg::CFG_GRID_WIDTH:   cfg.grid_width   <= cfg_data;
        afg_pkg::CFG_GRID_HEIGHT:  cfg.grid_height  <= cfg_data;
        afg_pkg::CFG_GRID_DEPTH:   cfg.grid_depth   <= cfg_data;
        default: ;
      endcase
    end
  end

  afg_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  afg_back #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: src/afg_checker.sv
module afg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input afg_pkg::result_t              result,
  input logic                          cfg_we,
  input logic [afg_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [afg_pkg::SIZE_W-1:0]    cfg_data
);

  logic mode3;

  // Track the grid mode as written on the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode3 <= 1'b0;
    end else if (cfg_we && cfg_index == afg_pkg::CFG_GRID_MODE) begin
      mode3 <= cfg_data[0];
    end
  end

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.index_error |->
      result.grid_x == '0 && result.grid_y == '0 && result.grid_z == '0)
    else $error("index error with nonzero coordinates");

  a_z_2d: assert property (@(posedge clk) disable iff (rst)
    !empty && !mode3 |-> result.grid_z == '0)
    else $error("z coordinate nonzero in 2D mode");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("input side filled without a transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed or vanished");

endmodule

bind affine_grid_generator afg_checker u_afg_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .result    (result),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
